FILE: src/bpwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpwd_pkg: shared types and constants of the beacon period window detector
// Ring geometry, averaging divisor, window reset values and stage structs.
// ----------------------------------------------------------------------------
package bpwd_pkg;

  // Ring of doubled periods
  localparam int RING_DEPTH = 8;
  localparam int RING_IDX_W = $clog2(RING_DEPTH);
  localparam int PERIOD_W   = 32;
  localparam int SUM_W      = PERIOD_W + RING_IDX_W;

  // Window registers and the reported average
  localparam int WIN_W = 27;
  localparam int AVG_W = 27;

  // average_us = sum * US_PER_MS / TICKS_PER_MS / RING_DEPTH = sum / AVG_DIV
  localparam int TICKS_PER_MS = 40000;
  localparam int US_PER_MS    = 1000;
  localparam int AVG_DIV      = TICKS_PER_MS * RING_DEPTH / US_PER_MS;

  // sum / 320 = (sum >> 6) / 5, the divide by 5 done by reciprocal multiply
  localparam int AVG_SHIFT       = 6;
  localparam int QUO_W           = SUM_W - AVG_SHIFT;
  localparam int RECIP_SHIFT     = 31;
  localparam int RECIP_W         = 29;
  localparam logic [RECIP_W-1:0] AVG_RECIP = 29'h1999_999A;
  localparam int PROD_W          = QUO_W + RECIP_W;

  // Window thresholds held in the sum domain
  localparam int THR_W = 36;
  localparam int WIN_LOW_RESET  = 1300;
  localparam int WIN_HIGH_RESET = 1800;

  // Register indexes
  localparam logic REG_WIN_LOW  = 1'b0;
  localparam logic REG_WIN_HIGH = 1'b1;

  // Operation codes
  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_QUERY   = 1'b1;

  typedef struct packed {
    logic                operation;
    logic [PERIOD_W-1:0] capture_time;
  } item_t;

  // Sum thresholds: hit when lo <= sum < hi
  typedef struct packed {
    logic [THR_W-1:0] lo;
    logic [THR_W-1:0] hi;
  } window_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [SUM_W-1:0]    sum;
    logic                hit;
  } result_t;

endpackage

FILE: src/bpwd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpwd_core: period ring, running sum and window test
// Applies one item to the detector state and registers its result.
// ----------------------------------------------------------------------------
module bpwd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  bpwd_pkg::item_t   item,
  input  bpwd_pkg::window_t win,
  output bpwd_pkg::result_t res
);
  import bpwd_pkg::*;

  logic [PERIOD_W-1:0]   previous_capture;
  logic [PERIOD_W-1:0]   latest_period;
  logic [PERIOD_W-1:0]   period_ring [RING_DEPTH];
  logic [RING_IDX_W-1:0] ring_index;
  logic [SUM_W-1:0]      ring_sum;

  logic [PERIOD_W-1:0]   diff;
  logic [PERIOD_W-1:0]   period_new;
  logic [SUM_W-1:0]      sum_capture;
  logic [SUM_W-1:0]      sum_test;
  logic [THR_W-1:0]      sum_ext;
  logic                  hit;
  logic [RING_IDX_W-1:0] ring_index_next;

  // Doubled edge-to-edge period, wrapped to 32 bits
  assign diff       = item.capture_time - previous_capture;
  assign period_new = {diff[PERIOD_W-2:0], 1'b0};

  // Replace the oldest entry in the running sum
  assign sum_capture = ring_sum - SUM_W'(period_ring[ring_index]) + SUM_W'(period_new);

  // Capture tests the updated sum, query tests the current one
  assign sum_test = (item.operation == OP_CAPTURE) ? sum_capture : ring_sum;
  assign sum_ext  = THR_W'(sum_test);
  assign hit      = (sum_ext >= win.lo) && (sum_ext < win.hi);

  assign ring_index_next = (ring_index == RING_IDX_W'(RING_DEPTH - 1)) ?
                           '0 : ring_index + 1'b1;

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_capture <= '0;
      latest_period    <= '0;
      ring_index       <= '0;
      ring_sum         <= '0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        period_ring[i] <= '0;
      end
    end else if (load) begin
      if (item.operation == OP_CAPTURE) begin
        previous_capture        <= item.capture_time;
        latest_period           <= period_new;
        period_ring[ring_index] <= period_new;
        ring_index              <= ring_index_next;
        ring_sum                <= sum_capture;
      end else if (hit) begin
        // hit on a query empties the ring
        ring_sum <= '0;
        for (int i = 0; i < RING_DEPTH; i++) begin
          period_ring[i] <= '0;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load) begin
      res.period <= (item.operation == OP_CAPTURE) ? period_new : latest_period;
      res.sum    <= sum_test;
      res.hit    <= hit;
    end
  end

endmodule

FILE: src/beacon_period_window_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beacon_period_window_detector: average beacon period window detector
// Capture timestamps feed an 8-entry period ring; queries test the average.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per transaction: tuser selects capture (0) or
//   query (1), tdata holds the capture timestamp (ignored on a query).
//   m_axis returns exactly one result per item, in order: latest doubled
//   period, average period in microseconds, and the in-window flag.
//   Window bounds are written through cfg_we/cfg_index/cfg_data while idle.
// Pipeline: an input transaction passes the input register, the state
//   update and the average multiply/output register before its result
//   is offered on m_axis.
// Throughput: one item per cycle unless m_axis stalls; the running sum and
//   the sum-domain window compare close in the state update stage, the
//   divide by 320 is a shift and one 29x29 reciprocal multiply in its own stage.
// Reset: ring, sum, indexes and pipeline valids clear; window returns to
//   1300..1800 us.
// Stall: each stage holds while the one after it is full and stalled, so
//   the block keeps taking items until all three stages are occupied.
// ----------------------------------------------------------------------------
module beacon_period_window_detector (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // [31:0] capture_time
  input  logic                          s_axis_tuser,  // [0] operation
  // Output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [63:0]                   m_axis_tdata,  // [31:0] period_ticks,
                                                       // [58:32] average_us,
                                                       // [59] in_window, rest 0
  // Configuration
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [bpwd_pkg::WIN_W-1:0]    cfg_data
);
  import bpwd_pkg::*;

  logic              a_valid;
  item_t             a_item;
  logic              b_valid;
  result_t           b_res;
  logic              c_valid;
  logic [PERIOD_W-1:0] c_period;
  logic [PROD_W-1:0] c_prod;
  logic              c_hit;

  logic              en_a;
  logic              en_b;
  logic              en_c;
  window_t           win;
  logic [THR_W-1:0]  cfg_ext;
  logic [QUO_W-1:0]  quo_in;

  // Stage enables
  assign en_c = !c_valid || m_axis_tready;
  assign en_b = !b_valid || en_c;
  assign en_a = !a_valid || en_b;
  assign s_axis_tready = en_a;

  // Window bounds converted to sum thresholds
  assign cfg_ext = THR_W'(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      win.lo <= THR_W'((WIN_LOW_RESET + 1) * AVG_DIV);
      win.hi <= THR_W'(WIN_HIGH_RESET * AVG_DIV);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIN_LOW:  win.lo <= (cfg_ext + 1'b1) * THR_W'(AVG_DIV);
        REG_WIN_HIGH: win.hi <= cfg_ext * THR_W'(AVG_DIV);
        default:      ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en_a) begin
      a_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && s_axis_tvalid) begin
      a_item.operation    <= s_axis_tuser;
      a_item.capture_time <= s_axis_tdata;
    end
  end

  // State update stage
  bpwd_core u_core (
    .clk  (clk),
    .rst  (rst),
    .load (en_b && a_valid),
    .item (a_item),
    .win  (win),
    .res  (b_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en_b) begin
      b_valid <= a_valid;
    end
  end

  // Average: (sum >> 6) * ceil(2^31 / 5) >> 31
  assign quo_in = b_res.sum[SUM_W-1:AVG_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en_c) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c && b_valid) begin
      c_period <= b_res.period;
      c_prod   <= PROD_W'(quo_in) * PROD_W'(AVG_RECIP);
      c_hit    <= b_res.hit;
    end
  end

  // Output packing
  assign m_axis_tvalid = c_valid;
  assign m_axis_tdata  = {4'b0, c_hit, c_prod[RECIP_SHIFT +: AVG_W], c_period};

endmodule

FILE: tb/bpwd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpwd_checker: result predictor and comparator for the window detector
// Watches the input stream, the result stream and the window register port.
// It keeps its own copy of the period ring, running sum and window, works out
// the result of every accepted item and checks each result transaction
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bpwd_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] capture_time
  input  logic        s_axis_tuser,   // [0] operation
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,   // [31:0] period_ticks, [58:32] average_us,
                                      // [59] in_window, rest 0
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [bpwd_pkg::WIN_W-1:0] cfg_data,
  output int          pending,
  output int          fails
);
  import bpwd_pkg::*;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [AVG_W-1:0]    avg_us;
    logic                in_win;
  } report_t;

  localparam longint unsigned AVG_CAP = (64'd1 << AVG_W) - 1;

  // Predicted detector state
  logic [WIN_W-1:0]    win_lo;
  logic [WIN_W-1:0]    win_hi;
  logic [PERIOD_W-1:0] prev_stamp;
  logic [PERIOD_W-1:0] last_period;
  logic [PERIOD_W-1:0] ring [RING_DEPTH];
  logic [RING_IDX_W-1:0] slot;
  logic [SUM_W-1:0]    ring_total;

  report_t reports_q[$];
  int      bad = 0;

  // Apply one item to the predicted state and return its report
  function automatic report_t advance_detector(input logic op, input logic [31:0] stamp);
    logic [63:0]         avg;
    logic                hit;
    logic [PERIOD_W-1:0] p;
    report_t             r;
    if (op == OP_CAPTURE) begin
      p = (stamp - prev_stamp) << 1;
      last_period = p;
      prev_stamp = stamp;
      ring_total = ring_total - ring[slot] + p;
      ring[slot] = p;
      slot = (slot == RING_DEPTH - 1) ? '0 : slot + 1'b1;
    end
    // full-width average in microseconds, window test is strict both ways
    avg = 64'(ring_total) * 64'(US_PER_MS) / 64'(TICKS_PER_MS) / 64'(RING_DEPTH);
    hit = (avg > 64'(win_lo)) && (avg < 64'(win_hi));
    // a query hit empties the ring; the slot index and last period stay
    if (op == OP_QUERY && hit) begin
      for (int i = 0; i < RING_DEPTH; i++) ring[i] = '0;
      ring_total = '0;
    end
    r.period = last_period;
    r.avg_us = (avg > AVG_CAP) ? AVG_CAP[AVG_W-1:0] : avg[AVG_W-1:0];
    r.in_win = hit;
    return r;
  endfunction

  task automatic flag(input string what, input logic [63:0] want, input logic [63:0] got);
    bad++;
    if (bad <= 10)
      $display("%0t bpwd_checker: %s mismatch, expected %0h, got %0h", $realtime, what,
               want, got);
  endtask

  always @(posedge clk) begin
    report_t r;
    if (rst) begin
      win_lo = WIN_W'(WIN_LOW_RESET);
      win_hi = WIN_W'(WIN_HIGH_RESET);
      prev_stamp = '0;
      last_period = '0;
      for (int i = 0; i < RING_DEPTH; i++) ring[i] = '0;
      slot = '0;
      ring_total = '0;
      reports_q.delete();
    end else begin
      // result side first: a result at this edge belongs to an older item
      if (m_axis_tvalid && m_axis_tready) begin
        if (reports_q.size() == 0) begin
          bad++;
          if (bad <= 10)
            $display("%0t bpwd_checker: result %0h with nothing outstanding", $realtime,
                     m_axis_tdata);
        end else begin
          r = reports_q.pop_front();
          if (m_axis_tdata[31:0] !== r.period) flag("period_ticks", r.period, m_axis_tdata[31:0]);
          if (m_axis_tdata[58:32] !== r.avg_us) flag("average_us", r.avg_us, m_axis_tdata[58:32]);
          if (m_axis_tdata[59] !== r.in_win) flag("in_window", r.in_win, m_axis_tdata[59]);
          if (m_axis_tdata[63:60] !== 4'h0) flag("padding", 0, m_axis_tdata[63:60]);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        reports_q.push_back(advance_detector(s_axis_tuser, s_axis_tdata));
      if (cfg_we) begin
        if (cfg_index == REG_WIN_LOW) win_lo = cfg_data;
        else win_hi = cfg_data;
      end
    end
    pending <= reports_q.size();
    fails   <= bad + reports_q.size();
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the beacon period window detector
// Drives capture and query transactions with random gaps and result stalls,
// moves the window through default, open, inverted, empty, narrow and random
// settings between phases, and leaves all checking to bpwd_checker.
// ----------------------------------------------------------------------------
module tb;
  import bpwd_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam logic [WIN_W-1:0] WIN_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [31:0]      s_axis_tdata  = '0;   // [31:0] capture_time
  logic             s_axis_tuser  = 1'b0; // [0] operation
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [63:0]      m_axis_tdata;         // [31:0] period_ticks, [58:32] average_us,
                                          // [59] in_window, rest 0
  logic             cfg_we    = 1'b0;
  logic             cfg_index = REG_WIN_LOW;
  logic [WIN_W-1:0] cfg_data  = '0;

  int pending;
  int fails;

  // Stimulus-side view of the window and the running timestamp
  logic [WIN_W-1:0] cur_lo = WIN_W'(WIN_LOW_RESET);
  logic [WIN_W-1:0] cur_hi = WIN_W'(WIN_HIGH_RESET);
  logic [31:0]      stamp  = '0;
  bit               tx_calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  beacon_period_window_detector u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  bpwd_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending       (pending),
    .fails         (fails)
  );

  // Result side: random stall after each transaction, calm stretches now and then
  int rx_hold = 0;
  bit rx_calm = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
        rx_hold = rx_calm ? 0 : $urandom_range(0, 4);
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      m_axis_tready <= (rx_hold == 0);
    end
  end

  // Watchdog on cycles with no transaction on either stream
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One input transaction; tvalid stays high for a back-to-back follower
  task automatic push(input logic op, input logic [31:0] t);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= t;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic capture_after(input logic [31:0] diff);
    stamp = stamp + diff;
    push(OP_CAPTURE, stamp);
  endtask

  // Hold off until every result is back, then let the pipeline empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_window(input logic [WIN_W-1:0] lo, input logic [WIN_W-1:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WIN_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= REG_WIN_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_lo = lo;
    cur_hi = hi;
  endtask

  // Mostly runs of captures spaced to land near the window centre, then a
  // query; the rest is stray captures, short broken runs and lone queries.
  task automatic run_shaped(input int n);
    int              done;
    int              roll;
    int              k;
    longint unsigned mid;
    longint unsigned span;
    longint unsigned base;
    done = 0;
    while (done < n) begin
      roll = $urandom_range(0, 99);
      mid  = (longint'(cur_lo) + longint'(cur_hi)) / 2 * 20;
      span = (cur_hi > cur_lo) ? (longint'(cur_hi) - longint'(cur_lo)) * 5 + 1 : 2000;
      base = (mid > span) ? mid - span : 0;
      if (roll < 70) begin
        k = $urandom_range(8, 12);
        repeat (k) capture_after(32'(base + $urandom_range(0, 32'(2 * span))));
        push(OP_QUERY, $urandom);
        done += k + 1;
      end else if (roll < 85) begin
        stamp = $urandom;
        push(OP_CAPTURE, stamp);
        done++;
      end else if (roll < 95) begin
        k = $urandom_range(1, 5);
        repeat (k) capture_after($urandom);
        push(OP_QUERY, $urandom);
        done += k + 1;
      end else begin
        push(OP_QUERY, $urandom);
        done++;
      end
      tx_calm = ($urandom_range(0, 4) == 0);
    end
  endtask

  initial begin
    logic [WIN_W-1:0] v;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: timestamp extremes, wrap of the doubled period, ignored
    // capture_time on a query, both strict window edges, hit and clear
    push(OP_CAPTURE, 32'h0000_0000);
    push(OP_CAPTURE, 32'hFFFF_FFFF);
    push(OP_CAPTURE, 32'h0000_0000);
    push(OP_QUERY,   32'hFFFF_FFFF);
    stamp = 32'h0;
    repeat (8) capture_after(26000);       // average exactly on the low bound
    push(OP_QUERY, 32'h0);
    capture_after(26160);                  // one slot nudges it to 1301 us
    push(OP_QUERY, 32'h5A5A_5A5A);         // hit, ring cleared
    push(OP_QUERY, 32'hA5A5_A5A5);         // empty ring, miss
    repeat (8) capture_after(36000);       // average exactly on the high bound
    push(OP_QUERY, 32'h0);
    run_shaped(300);
    settle();

    // Window wide open
    load_window('0, WIN_MAX);
    run_shaped(250);
    settle();

    // Inverted window: never a hit
    load_window(WIN_MAX, '0);
    run_shaped(150);
    settle();

    // Empty window, low equals high
    v = WIN_W'($urandom_range(1000, 2000));
    load_window(v, v);
    run_shaped(100);
    settle();

    // Random narrow-ish windows
    v = WIN_W'($urandom_range(0, 134000000));
    load_window(v, WIN_W'(v + $urandom_range(1, 200000)));
    run_shaped(300);
    settle();

    // Tight window of one microsecond inside
    load_window(WIN_W'(1000), WIN_W'(1002));
    run_shaped(200);
    settle();

    // Top of the range, very long periods
    load_window(WIN_W'(100000000), WIN_MAX);
    run_shaped(200);
    settle();

    // Fully random bounds
    load_window(WIN_W'($urandom), WIN_W'($urandom));
    run_shaped(250);
    settle();

    repeat (16) @(posedge clk);
    if (fails == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
